>>> hw/rtl/nalsc_pkg.sv
// nalsc_pkg: shared types, constants and codes of the nested argument-list checker
// used by nalsc_ctrl, nalsc_dpath and nested_arg_list_syntax_checker_top
`default_nettype none

package nalsc_pkg;

  // sizes
  localparam int POS_W     = 16;
  localparam int MAX_DEPTH = 16;
  localparam int NEST_W    = $clog2(MAX_DEPTH + 1);
  localparam int EV_CAP    = MAX_DEPTH + 4;
  localparam int CNT_W     = $clog2(EV_CAP + 1);

  // result kinds
  localparam logic [2:0] EV_TOKEN  = 3'd0;
  localparam logic [2:0] EV_OPEN   = 3'd1;
  localparam logic [2:0] EV_CLOSE  = 3'd2;
  localparam logic [2:0] EV_ERROR  = 3'd3;
  localparam logic [2:0] EV_FINISH = 3'd4;

  // error codes
  localparam logic [2:0] ERR_UNEXPECTED   = 3'd0;
  localparam logic [2:0] ERR_WRONG_DELIM  = 3'd1;
  localparam logic [2:0] ERR_DELIM_CLOSE  = 3'd2;
  localparam logic [2:0] ERR_COMMA_EXP    = 3'd3;
  localparam logic [2:0] ERR_SEMI_EXP     = 3'd4;
  localparam logic [2:0] ERR_DELIM_EXP    = 3'd5;
  localparam logic [2:0] ERR_UNTERMINATED = 3'd6;
  localparam logic [2:0] ERR_OVERFLOW     = 3'd7;

  // character class of an accepted item
  typedef enum logic [2:0] {
    CL_WS,
    CL_DELIM,
    CL_CLOSE,
    CL_TOKEN,
    CL_FIN
  } cls_e;

  // delimiter being processed
  typedef enum logic [1:0] {
    DL_OPEN,
    DL_COMMA,
    DL_SEMI
  } dlm_e;

  // where a delimiter sequence returns to
  typedef enum logic [1:0] {
    CTX_CHAR,
    CTX_TOK,
    CTX_FIN
  } ctx_e;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_POS,
    S_WS,
    S_CLOSE,
    S_TOK1,
    S_TOK2,
    S_D0,
    S_D1,
    S_D2,
    S_D3,
    S_CLOSES,
    S_INC,
    S_FIN,
    S_FINEV,
    S_FLUSH
  } ctl_state_e;

  // datapath operations
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_POS,
    OP_WS,
    OP_CLOSE,
    OP_TOK1,
    OP_TOK2,
    OP_D0,
    OP_D1,
    OP_D2,
    OP_D3,
    OP_CLOSES,
    OP_INC,
    OP_FIN,
    OP_FINEV,
    OP_FLUSH
  } op_e;

  // parse flags
  typedef struct packed {
    logic open_pending;
    logic sep_seen;
    logic delim_at_close;
    logic empty_args;
    logic may_start;
    logic in_token;
  } flags_t;

  // one result item without its last mark
  typedef struct packed {
    logic [2:0]        kind;
    logic [POS_W-1:0]  tok_start;
    logic [POS_W-1:0]  tok_end;
    logic [NEST_W-1:0] depth;
    logic [2:0]        code;
    logic              ok;
  } evt_t;

  // controller to datapath
  typedef struct packed {
    op_e  op;
    logic accept;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic blocked;
    cls_e cls;
    logic abort0;
    logic delim_at_close;
    logic empty_args;
    logic dch_open;
    logic pend_zero;
    logic in_token;
    logic may_start;
    logic nest_zero;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/nalsc_ctrl.sv
// nalsc_ctrl: sequencer that walks one item through its parse steps
// depends on nalsc_pkg; drives nalsc_dpath by command and reads its status
`default_nettype none

module nalsc_ctrl
  import nalsc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  output dp_cmd_t       cmd_o,
  input  wire dp_stat_t stat_i
);

  ctl_state_e state_q, state_d;
  ctx_e       ctx_q, ctx_d;

  // return point after a delimiter sequence
  ctl_state_e cont_s;
  always_comb begin
    case (ctx_q)
      CTX_TOK: cont_s = S_TOK2;
      CTX_FIN: cont_s = S_FINEV;
      default: cont_s = S_INC;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    ctx_d   = ctx_q;
    if (!stat_i.blocked) begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_d = S_POS;
        end
        S_POS: begin
          case (stat_i.cls)
            CL_FIN:   state_d = S_FIN;
            CL_WS:    state_d = S_WS;
            CL_CLOSE: state_d = S_CLOSE;
            CL_TOKEN: state_d = S_TOK1;
            default: begin
              state_d = S_D0;
              ctx_d   = CTX_CHAR;
            end
          endcase
        end
        S_WS:    state_d = S_INC;
        S_CLOSE: state_d = S_INC;
        S_TOK1: begin
          if (stat_i.in_token) begin
            state_d = S_INC;
          end else if (!stat_i.may_start) begin
            state_d = S_D0;
            ctx_d   = CTX_TOK;
          end else begin
            state_d = S_TOK2;
          end
        end
        S_TOK2: state_d = S_INC;
        S_D0: begin
          if (stat_i.abort0) state_d = cont_s;
          else if (stat_i.delim_at_close) state_d = S_CLOSES;
          else state_d = S_D1;
        end
        S_D1: begin
          state_d = stat_i.empty_args ? S_CLOSES : S_D2;
        end
        S_D2: begin
          state_d = stat_i.dch_open ? S_D3 : S_CLOSES;
        end
        S_D3: state_d = S_CLOSES;
        S_CLOSES: begin
          if (stat_i.pend_zero) state_d = cont_s;
        end
        S_INC: state_d = S_FLUSH;
        S_FIN: begin
          ctx_d = CTX_FIN;
          if (!stat_i.may_start) state_d = S_D0;
          else if (!stat_i.nest_zero) state_d = S_CLOSES;
          else state_d = S_FINEV;
        end
        S_FINEV: state_d = S_FLUSH;
        S_FLUSH: state_d = S_IDLE;
        default: state_d = S_IDLE;
      endcase
    end
  end

  // command outputs
  always_comb begin
    in_stall_o   = (state_q != S_IDLE);
    cmd_o.accept = (state_q == S_IDLE) && in_valid_i;
    case (state_q)
      S_POS:    cmd_o.op = OP_POS;
      S_WS:     cmd_o.op = OP_WS;
      S_CLOSE:  cmd_o.op = OP_CLOSE;
      S_TOK1:   cmd_o.op = OP_TOK1;
      S_TOK2:   cmd_o.op = OP_TOK2;
      S_D0:     cmd_o.op = OP_D0;
      S_D1:     cmd_o.op = OP_D1;
      S_D2:     cmd_o.op = OP_D2;
      S_D3:     cmd_o.op = OP_D3;
      S_CLOSES: cmd_o.op = OP_CLOSES;
      S_INC:    cmd_o.op = OP_INC;
      S_FIN:    cmd_o.op = OP_FIN;
      S_FINEV:  cmd_o.op = OP_FINEV;
      S_FLUSH:  cmd_o.op = OP_FLUSH;
      default:  cmd_o.op = OP_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ctx_q   <= CTX_CHAR;
    end else begin
      state_q <= state_d;
      ctx_q   <= ctx_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/nalsc_dpath.sv
// nalsc_dpath: parse state, step operations, result hold stage and output register
// depends on nalsc_pkg; sequenced by nalsc_ctrl
`default_nettype none

module nalsc_dpath
  import nalsc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_wdata_i,
  input  wire logic [7:0] in_ch_i,
  input  wire logic       in_end_of_input_i,
  input  wire dp_cmd_t    cmd_i,
  output dp_stat_t        stat_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output evt_t            out_evt_o,
  output logic            out_last_o
);

  // character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SEMI  = 8'h3B;

  localparam logic [NEST_W-1:0] MAX_NEST = NEST_W'(MAX_DEPTH);
  localparam logic [CNT_W-1:0]  CNT_CAP  = CNT_W'(EV_CAP);
  localparam flags_t FLAGS_RST = '{may_start: 1'b1, default: 1'b0};

  function automatic cls_e char_class(input logic [7:0] ch, input logic eoi);
    cls_e c;
    if (eoi || ch == CH_NUL) begin
      c = CL_FIN;
    end else begin
      case (ch)
        CH_SP, CH_LF, CH_CR, CH_TAB: c = CL_WS;
        CH_OPEN, CH_COMMA, CH_SEMI:  c = CL_DELIM;
        CH_CLOSE:                    c = CL_CLOSE;
        default:                     c = CL_TOKEN;
      endcase
    end
    return c;
  endfunction

  function automatic dlm_e char_delim(input logic [7:0] ch);
    dlm_e d;
    case (ch)
      CH_OPEN:  d = DL_OPEN;
      CH_COMMA: d = DL_COMMA;
      default:  d = DL_SEMI;
    endcase
    return d;
  endfunction

  function automatic evt_t mk_evt(input logic [2:0] kind, input logic [POS_W-1:0] a,
                                  input logic [POS_W-1:0] b, input logic [NEST_W-1:0] d,
                                  input logic [2:0] code, input logic ok);
    evt_t e;
    e.kind      = kind;
    e.tok_start = a;
    e.tok_end   = b;
    e.depth     = d;
    e.code      = code;
    e.ok        = ok;
    return e;
  endfunction

  // parse state
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [NEST_W-1:0] nest_q, nest_d;
  logic [NEST_W-1:0] pend_q, pend_d;
  logic [POS_W-1:0]  tstart_q, tstart_d;
  logic [POS_W-1:0]  tend_q, tend_d;
  logic              tend_v_q, tend_v_d;
  flags_t            flags_q, flags_d;
  logic              success_q, success_d;
  logic              trace_q;
  cls_e              cls_q, cls_d;
  dlm_e              dch_q, dch_d;

  // result path
  logic [CNT_W-1:0]  cnt_q;
  evt_t              hold_q;
  logic              hold_v_q;
  evt_t              out_q;
  logic              out_last_q;
  logic              out_v_q;

  evt_t              ev;
  logic              ev_want;

  // derived values
  logic              pos_sat;
  logic [POS_W-1:0]  pos_m1;
  logic [NEST_W-1:0] nest_m1;
  logic              arg_nz;
  logic              abort0;
  logic [POS_W-1:0]  tend_eff;

  assign pos_sat  = (pos_q == {POS_W{1'b1}});
  assign pos_m1   = (pos_q != '0) ? pos_q - POS_W'(1) : '0;
  assign nest_m1  = (nest_q != '0) ? nest_q - NEST_W'(1) : '0;
  assign arg_nz   = (nest_q > pend_q);
  assign abort0   = (flags_q.may_start && !flags_q.empty_args) ||
                    (dch_q == DL_OPEN && pend_q != '0);
  assign tend_eff = tend_v_q ? tend_q : pos_m1;

  // step operations
  always_comb begin
    pos_d     = pos_q;
    nest_d    = nest_q;
    pend_d    = pend_q;
    tstart_d  = tstart_q;
    tend_d    = tend_q;
    tend_v_d  = tend_v_q;
    flags_d   = flags_q;
    success_d = success_q;
    cls_d     = cls_q;
    dch_d     = dch_q;
    ev_want   = 1'b0;
    ev        = '0;
    case (cmd_i.op)
      OP_IDLE: begin
        if (cmd_i.accept) begin
          cls_d = char_class(in_ch_i, in_end_of_input_i);
          dch_d = char_delim(in_ch_i);
        end
      end
      OP_POS: begin
        if (cls_q != CL_FIN && pos_sat) begin
          ev_want   = 1'b1;
          ev        = mk_evt(EV_ERROR, pos_q, pos_q, nest_q, ERR_OVERFLOW, 1'b0);
          success_d = 1'b0;
        end
      end
      OP_WS: begin
        if (flags_q.in_token) begin
          tend_d           = pos_m1;
          tend_v_d         = 1'b1;
          flags_d.in_token = 1'b0;
        end
      end
      OP_CLOSE: begin
        if (flags_q.in_token) begin
          tend_d           = pos_m1;
          tend_v_d         = 1'b1;
          flags_d.in_token = 1'b0;
        end
        if (arg_nz) begin
          pend_d = pend_q + NEST_W'(1);
          if (flags_q.sep_seen) begin
            ev_want                = 1'b1;
            ev = mk_evt(EV_ERROR, pos_q, pos_q, nest_q, ERR_DELIM_CLOSE, 1'b0);
            success_d              = 1'b0;
            flags_d.sep_seen       = 1'b0;
            flags_d.may_start      = 1'b0;
            flags_d.delim_at_close = 1'b1;
          end else if (flags_q.may_start) begin
            flags_d.may_start  = 1'b0;
            flags_d.empty_args = 1'b1;
          end
        end else begin
          ev_want   = 1'b1;
          ev        = mk_evt(EV_ERROR, pos_q, pos_q, nest_q, ERR_UNEXPECTED, 1'b0);
          success_d = 1'b0;
        end
      end
      OP_TOK1: begin
        // missing separator: report it and queue an implied one
        if (!flags_q.in_token && !flags_q.may_start) begin
          ev_want   = 1'b1;
          ev        = mk_evt(EV_ERROR, pos_q, pos_q, nest_q,
                             arg_nz ? ERR_COMMA_EXP : ERR_SEMI_EXP, 1'b0);
          success_d = 1'b0;
          dch_d     = arg_nz ? DL_COMMA : DL_SEMI;
        end
      end
      OP_TOK2: begin
        if (flags_q.may_start) begin
          flags_d.in_token  = 1'b1;
          flags_d.may_start = 1'b0;
          flags_d.sep_seen  = 1'b0;
          tstart_d          = pos_q;
          tend_v_d          = 1'b0;
        end
      end
      OP_D0: begin
        if (abort0) begin
          ev_want   = 1'b1;
          ev        = mk_evt(EV_ERROR, pos_q, pos_q, nest_q, ERR_UNEXPECTED, 1'b0);
          success_d = 1'b0;
        end else begin
          if ((dch_q == DL_SEMI && arg_nz) || (dch_q == DL_COMMA && !arg_nz)) begin
            ev_want   = 1'b1;
            ev        = mk_evt(EV_ERROR, pos_q, pos_q, nest_q, ERR_WRONG_DELIM, 1'b0);
            success_d = 1'b0;
          end
          if (nest_q != '0 && dch_q != DL_OPEN) flags_d.sep_seen = 1'b1;
          flags_d.in_token       = 1'b0;
          flags_d.may_start      = 1'b1;
          flags_d.delim_at_close = 1'b0;
        end
      end
      OP_D1: begin
        if (flags_q.open_pending) begin
          flags_d.open_pending = 1'b0;
          if (!flags_q.empty_args && trace_q) begin
            ev_want = 1'b1;
            ev      = mk_evt(EV_OPEN, '0, '0, nest_m1, '0, 1'b0);
          end
        end
      end
      OP_D2: begin
        if (!tend_v_q) begin
          tend_d   = pos_m1;
          tend_v_d = 1'b1;
        end
        if (tend_eff >= tstart_q && trace_q) begin
          ev_want = 1'b1;
          ev      = mk_evt(EV_TOKEN, tstart_q, tend_eff, nest_q, '0, 1'b0);
        end
      end
      OP_D3: begin
        if (nest_q >= MAX_NEST) begin
          ev_want   = 1'b1;
          ev        = mk_evt(EV_ERROR, pos_q, pos_q, nest_q, ERR_OVERFLOW, 1'b0);
          success_d = 1'b0;
        end else begin
          nest_d               = nest_q + NEST_W'(1);
          flags_d.open_pending = 1'b1;
        end
      end
      OP_CLOSES: begin
        // one waiting close per step; an empty list swallows its close event
        if (pend_q != '0) begin
          nest_d = nest_m1;
          pend_d = pend_q - NEST_W'(1);
          if (!flags_q.empty_args) begin
            if (trace_q) begin
              ev_want = 1'b1;
              ev      = mk_evt(EV_CLOSE, '0, '0, nest_m1, '0, 1'b0);
            end
          end else begin
            flags_d.empty_args = 1'b0;
          end
        end
      end
      OP_INC: begin
        if (!pos_sat) pos_d = pos_q + POS_W'(1);
      end
      OP_FIN: begin
        if (!flags_q.may_start) begin
          ev_want   = 1'b1;
          ev        = mk_evt(EV_ERROR, pos_q, pos_q, nest_q, ERR_DELIM_EXP, 1'b0);
          success_d = 1'b0;
          dch_d     = arg_nz ? DL_COMMA : DL_SEMI;
        end else if (nest_q != '0) begin
          ev_want   = 1'b1;
          ev        = mk_evt(EV_ERROR, pos_q, pos_q, nest_q, ERR_UNTERMINATED, 1'b0);
          success_d = 1'b0;
          pend_d    = nest_q;
        end
      end
      OP_FINEV: begin
        ev_want   = 1'b1;
        ev        = mk_evt(EV_FINISH, '0, '0, nest_q, '0, success_q);
        // back to the start of a new stream
        pos_d     = '0;
        nest_d    = '0;
        pend_d    = '0;
        tstart_d  = '0;
        tend_d    = '0;
        tend_v_d  = 1'b0;
        flags_d   = FLAGS_RST;
        success_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // result path control: the newest item waits in the hold stage until the
  // next one shows up or the input item is done, so its last mark is known
  logic out_take, out_free, ev_put, flush, blocked, move;
  assign out_take = out_v_q && !out_stall_i;
  assign out_free = !out_v_q || out_take;
  assign ev_put   = ev_want && (cnt_q < CNT_CAP);
  assign flush    = (cmd_i.op == OP_FLUSH) && hold_v_q;
  assign blocked  = (ev_put || flush) && hold_v_q && !out_free;
  assign move     = !blocked && hold_v_q && (ev_put || flush);

  // parse state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      nest_q    <= '0;
      pend_q    <= '0;
      tstart_q  <= '0;
      tend_q    <= '0;
      tend_v_q  <= 1'b0;
      flags_q   <= FLAGS_RST;
      success_q <= 1'b1;
    end else if (!blocked) begin
      pos_q     <= pos_d;
      nest_q    <= nest_d;
      pend_q    <= pend_d;
      tstart_q  <= tstart_d;
      tend_q    <= tend_d;
      tend_v_q  <= tend_v_d;
      flags_q   <= flags_d;
      success_q <= success_d;
    end
  end

  // trace enable register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trace_q <= 1'b1;
    end else if (cfg_we_i) begin
      trace_q <= cfg_wdata_i;
    end
  end

  // latched item class and delimiter
  always_ff @(posedge clk_i) begin
    if (!blocked) begin
      cls_q <= cls_d;
      dch_q <= dch_d;
    end
  end

  // result counters and valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        cnt_q <= '0;
      end else if (!blocked && ev_put) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (!blocked && ev_put) begin
        hold_v_q <= 1'b1;
      end else if (move) begin
        hold_v_q <= 1'b0;
      end
      if (move) begin
        out_v_q <= 1'b1;
      end else if (out_take) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (!blocked && ev_put) begin
      hold_q <= ev;
    end
    if (move) begin
      out_q      <= hold_q;
      out_last_q <= flush;
    end
  end

  // status to the sequencer
  always_comb begin
    stat_o.blocked        = blocked;
    stat_o.cls            = cls_q;
    stat_o.abort0         = abort0;
    stat_o.delim_at_close = flags_q.delim_at_close;
    stat_o.empty_args     = flags_q.empty_args;
    stat_o.dch_open       = (dch_q == DL_OPEN);
    stat_o.pend_zero      = (pend_q == '0);
    stat_o.in_token       = flags_q.in_token;
    stat_o.may_start      = flags_q.may_start;
    stat_o.nest_zero      = (nest_q == '0);
  end

  assign out_valid_o = out_v_q;
  assign out_evt_o   = out_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

>>> hw/rtl/nested_arg_list_syntax_checker_top.sv
// Nested argument-list syntax checker, one character item in, trace results out.
// A character is accepted only while the block is idle. The step sequencer in
// nalsc_ctrl walks each item through its parse steps, one parse step per cycle;
// a ',' or ';' runs the delimiter steps, a '(' adds a nesting step to them, and
// the close step repeats for every waiting group close applied. A token
// character that needs an implied separator also runs the delimiter steps. A
// step that has to place a result waits while the output register is held by
// stall. An end item repeats the close step for every group left open.
// Results of one item come out in order, the last one marked with out_last_o;
// after the finish result the parse starts over. emit_trace (cfg_wdata_i,
// reset 1) may be written only while the block is idle.
// depends on nalsc_pkg, nalsc_ctrl and nalsc_dpath
`default_nettype none

module nested_arg_list_syntax_checker_top
  import nalsc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [7:0]        in_ch_i,
  input  wire logic              in_end_of_input_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [2:0]             out_kind_o,
  output logic [POS_W-1:0]       out_tok_start_o,
  output logic [POS_W-1:0]       out_tok_end_o,
  output logic [NEST_W-1:0]      out_depth_o,
  output logic [2:0]             out_error_code_o,
  output logic                   out_ok_o,
  output logic                   out_last_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  evt_t     out_evt;

  // step sequencer
  nalsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  // parse state and result path
  nalsc_dpath u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_ch_i           (in_ch_i),
    .in_end_of_input_i (in_end_of_input_i),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_evt_o         (out_evt),
    .out_last_o        (out_last_o)
  );

  // result fields
  assign out_kind_o       = out_evt.kind;
  assign out_tok_start_o  = out_evt.tok_start;
  assign out_tok_end_o    = out_evt.tok_end;
  assign out_depth_o      = out_evt.depth;
  assign out_error_code_o = out_evt.code;
  assign out_ok_o         = out_evt.ok;

`ifndef SYNTHESIS
  // a finish result always closes the results of its item
  a_finish_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o == EV_FINISH |-> out_last_o)
    else $error("finish result without last mark");

  // only error results carry an error code
  a_code_err_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o != EV_ERROR |-> out_error_code_o == 3'd0)
    else $error("error code on a non-error result");

  // an accepted item keeps the input stalled while it is worked on
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accept");

  // reported depth never exceeds the nesting limit
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_depth_o <= NEST_W'(MAX_DEPTH))
    else $error("result depth beyond nesting limit");
`endif

endmodule

`default_nettype wire

>>> dv/testbench.sv
// testbench for nested_arg_list_syntax_checker_top: random and directed character streams,
// a cycle-free parse predictor and an in-order check of every trace result
// depends on nalsc_pkg and the checker rtl
`default_nettype none

module testbench;
  import nalsc_pkg::*;

  // character constants
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = " ";
  localparam logic [7:0] CH_OPEN  = "(";
  localparam logic [7:0] CH_CLOSE = ")";
  localparam logic [7:0] CH_COMMA = ",";
  localparam logic [7:0] CH_SEMI  = ";";

  localparam logic [POS_W-1:0] POS_LIMIT = '1;

  // one character item as sent
  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
  } char_item_t;

  // one trace result as predicted
  typedef struct packed {
    logic [2:0]        kind;
    logic [POS_W-1:0]  first_pos;
    logic [POS_W-1:0]  last_pos;
    logic [NEST_W-1:0] depth;
    logic [2:0]        code;
    logic              ok;
    logic              last;
  } trace_event_t;

  typedef enum logic [1:0] {
    ST_NONE,
    ST_LIGHT,
    ST_HEAVY,
    ST_PERIODIC
  } stall_mode_e;

  logic              clk_i = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic              cfg_wdata = 1'b0;
  logic              in_valid = 1'b0;
  logic [7:0]        in_ch = 8'h00;
  logic              in_eoi = 1'b0;
  logic              out_stall = 1'b0;
  logic              in_stall_o;
  logic              out_valid_o;
  logic [2:0]        out_kind_o;
  logic [POS_W-1:0]  out_tok_start_o;
  logic [POS_W-1:0]  out_tok_end_o;
  logic [NEST_W-1:0] out_depth_o;
  logic [2:0]        out_error_code_o;
  logic              out_ok_o;
  logic              out_last_o;

  nested_arg_list_syntax_checker_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_wdata_i       (cfg_wdata),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall_o),
    .in_ch_i           (in_ch),
    .in_end_of_input_i (in_eoi),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall),
    .out_kind_o        (out_kind_o),
    .out_tok_start_o   (out_tok_start_o),
    .out_tok_end_o     (out_tok_end_o),
    .out_depth_o       (out_depth_o),
    .out_error_code_o  (out_error_code_o),
    .out_ok_o          (out_ok_o),
    .out_last_o        (out_last_o)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #50_000_000;
    $display("FAIL");
    $finish;
  end

  char_item_t   pending_chars[$];
  trace_event_t predicted_events[$];
  int           n_queued = 0;
  int           n_accepted = 0;
  int           mismatches = 0;
  logic         noise_on = 1'b0;

  // ---------------------------------------------------------------------------
  // parse predictor
  // ---------------------------------------------------------------------------
  logic              trace_on;
  logic [POS_W-1:0]  pos_q;
  logic [NEST_W-1:0] nest_q;
  logic [NEST_W-1:0] pend_q;
  logic [POS_W-1:0]  tok_first_q;
  logic [POS_W-1:0]  tok_last_q;
  logic              tok_last_ok_q;
  flags_t            flags_q;
  logic              clean_q;
  trace_event_t      step_events[EV_CAP];
  int                step_count;

  function automatic void add_event(logic [2:0] kind, logic [POS_W-1:0] first_pos,
                                    logic [POS_W-1:0] last_pos, logic [NEST_W-1:0] depth,
                                    logic [2:0] code, logic ok);
    if (step_count < EV_CAP) begin
      step_events[step_count] = '{kind: kind, first_pos: first_pos, last_pos: last_pos,
                                  depth: depth, code: code, ok: ok, last: 1'b0};
      step_count++;
    end
  endfunction

  function automatic void report_error(logic [2:0] code);
    clean_q = 1'b0;
    add_event(EV_ERROR, pos_q, pos_q, nest_q, code, 1'b0);
  endfunction

  // depth of the argument list a character lands in
  function automatic logic [NEST_W-1:0] open_level();
    return (nest_q >= pend_q) ? nest_q - pend_q : '0;
  endfunction

  function automatic logic [POS_W-1:0] prev_pos();
    return (pos_q != 0) ? pos_q - 1'b1 : '0;
  endfunction

  function automatic void apply_pending_closes();
    while (pend_q != 0) begin
      if (nest_q != 0) nest_q--;
      if (!flags_q.empty_args) begin
        if (trace_on) add_event(EV_CLOSE, '0, '0, nest_q, '0, 1'b0);
      end else begin
        flags_q.empty_args = 1'b0;
      end
      pend_q--;
    end
  endfunction

  function automatic void end_token();
    if (flags_q.in_token) begin
      tok_last_q = prev_pos();
      tok_last_ok_q = 1'b1;
      flags_q.in_token = 1'b0;
    end
  endfunction

  function automatic void take_delimiter(dlm_e dl);
    logic [NEST_W-1:0] arg;
    arg = open_level();
    if ((flags_q.may_start && !flags_q.empty_args) || (dl == DL_OPEN && pend_q != 0)) begin
      report_error(ERR_UNEXPECTED);
      return;
    end
    if ((dl == DL_SEMI && arg != 0) || (dl == DL_COMMA && arg == 0))
      report_error(ERR_WRONG_DELIM);
    if (nest_q != 0 && dl != DL_OPEN) flags_q.sep_seen = 1'b1;
    flags_q.in_token = 1'b0;
    flags_q.may_start = 1'b1;
    // separator right after a faulty close only applies the closes
    if (flags_q.delim_at_close) begin
      flags_q.delim_at_close = 1'b0;
      apply_pending_closes();
      return;
    end
    if (flags_q.open_pending) begin
      flags_q.open_pending = 1'b0;
      if (!flags_q.empty_args && trace_on)
        add_event(EV_OPEN, '0, '0, (nest_q != 0) ? nest_q - 1'b1 : '0, '0, 1'b0);
    end
    if (flags_q.empty_args) begin
      apply_pending_closes();
      return;
    end
    if (!tok_last_ok_q) begin
      tok_last_q = prev_pos();
      tok_last_ok_q = 1'b1;
    end
    if (tok_last_q >= tok_first_q && trace_on)
      add_event(EV_TOKEN, tok_first_q, tok_last_q, nest_q, '0, 1'b0);
    if (dl == DL_OPEN) begin
      if (nest_q >= MAX_DEPTH) begin
        report_error(ERR_OVERFLOW);
      end else begin
        nest_q++;
        flags_q.open_pending = 1'b1;
      end
    end
    apply_pending_closes();
  endfunction

  function automatic void take_close();
    end_token();
    if (open_level() != 0) begin
      pend_q++;
    end else begin
      report_error(ERR_UNEXPECTED);
      return;
    end
    if (flags_q.sep_seen) begin
      report_error(ERR_DELIM_CLOSE);
      flags_q.sep_seen = 1'b0;
      flags_q.may_start = 1'b0;
      flags_q.delim_at_close = 1'b1;
    end else if (flags_q.may_start) begin
      flags_q.may_start = 1'b0;
      flags_q.empty_args = 1'b1;
    end
  endfunction

  function automatic void take_name_char();
    logic [NEST_W-1:0] arg;
    arg = open_level();
    if (flags_q.in_token) return;
    // missing separator: report it and insert the implied one
    if (!flags_q.may_start) begin
      report_error((arg != 0) ? ERR_COMMA_EXP : ERR_SEMI_EXP);
      take_delimiter((arg != 0) ? DL_COMMA : DL_SEMI);
    end
    if (flags_q.may_start) begin
      flags_q.in_token = 1'b1;
      flags_q.may_start = 1'b0;
      flags_q.sep_seen = 1'b0;
      tok_first_q = pos_q;
      tok_last_ok_q = 1'b0;
    end
  endfunction

  function automatic void parse_reset();
    pos_q = '0;
    nest_q = '0;
    pend_q = '0;
    tok_first_q = '0;
    tok_last_q = '0;
    tok_last_ok_q = 1'b0;
    flags_q = '0;
    flags_q.may_start = 1'b1;
    clean_q = 1'b1;
  endfunction

  function automatic void take_end();
    logic okv;
    if (!flags_q.may_start) begin
      report_error(ERR_DELIM_EXP);
      take_delimiter((open_level() != 0) ? DL_COMMA : DL_SEMI);
      okv = 1'b0;
    end else if (nest_q != 0) begin
      report_error(ERR_UNTERMINATED);
      pend_q = nest_q;
      apply_pending_closes();
      okv = 1'b0;
    end else begin
      okv = clean_q;
    end
    add_event(EV_FINISH, '0, '0, nest_q, '0, okv);
    parse_reset();
  endfunction

  // expected results of one accepted item
  function automatic void predict_item(logic [7:0] ch, logic eoi);
    trace_event_t ev;
    step_count = 0;
    if (eoi || ch == CH_NUL) begin
      take_end();
    end else begin
      if (pos_q == POS_LIMIT) report_error(ERR_OVERFLOW);
      case (ch)
        CH_SPACE, CH_LF, CH_CR, CH_TAB: end_token();
        CH_OPEN:  take_delimiter(DL_OPEN);
        CH_COMMA: take_delimiter(DL_COMMA);
        CH_SEMI:  take_delimiter(DL_SEMI);
        CH_CLOSE: take_close();
        default:  take_name_char();
      endcase
      if (pos_q != POS_LIMIT) pos_q++;
    end
    for (int i = 0; i < step_count; i++) begin
      ev = step_events[i];
      ev.last = (i == step_count - 1);
      predicted_events.push_back(ev);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // monitor and checker
  // ---------------------------------------------------------------------------
  logic in_taken = 1'b0;

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    trace_event_t want;
    if (rst_n) begin
      if (cfg_we) trace_on = cfg_wdata;
      in_taken <= in_valid && !in_stall_o;
      if (in_valid && !in_stall_o) begin
        predict_item(in_ch, in_eoi);
        n_accepted++;
      end
      if (out_valid_o && !out_stall) begin
        if (predicted_events.size() == 0) begin
          $error("kind: no result expected, got %0d", out_kind_o);
          mismatches++;
        end else begin
          want = predicted_events.pop_front();
          check_field("kind", want.kind, out_kind_o);
          check_field("tok_start", want.first_pos, out_tok_start_o);
          check_field("tok_end", want.last_pos, out_tok_end_o);
          check_field("depth", want.depth, out_depth_o);
          check_field("error_code", want.code, out_error_code_o);
          check_field("ok", want.ok, out_ok_o);
          check_field("last", want.last, out_last_o);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // driver: bursts with random gaps, now and then waits for all results
  // ---------------------------------------------------------------------------
  int   burst_left = 0;
  int   gap_left = 0;
  logic hold_drain = 1'b0;

  always @(negedge clk_i) begin
    char_item_t nxt;
    if (rst_n && !(in_valid && !in_taken)) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_chars.size() == 0 ||
                   (hold_drain && predicted_events.size() != 0)) begin
        in_valid <= 1'b0;
      end else begin
        nxt = pending_chars.pop_front();
        in_ch <= nxt.ch;
        in_eoi <= nxt.eoi;
        in_valid <= 1'b1;
        hold_drain = 1'b0;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          if ($urandom_range(0, 2) == 0) gap_left = 0;
          else gap_left = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 15 : 3);
          hold_drain = ($urandom_range(0, 29) == 0);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver stall pattern
  // ---------------------------------------------------------------------------
  stall_mode_e stall_mode = ST_NONE;
  int          stall_run = 0;
  int          stall_phase = 0;

  always @(negedge clk_i) begin
    if (stall_run == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_run = $urandom_range(16, 160);
    end else begin
      stall_run--;
    end
    stall_phase++;
    case (stall_mode)
      ST_NONE:  out_stall <= 1'b0;
      ST_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      ST_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:  out_stall <= (stall_phase % 5 < 2);
    endcase
  end

  // ---------------------------------------------------------------------------
  // stimulus builders
  // ---------------------------------------------------------------------------
  function automatic void put_char(logic [7:0] c);
    pending_chars.push_back('{ch: c, eoi: 1'b0});
    n_queued++;
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) put_char(s[i]);
  endfunction

  // end of stream, either an end marker with a junk byte or a nul character
  function automatic void put_finish(logic by_nul, logic [7:0] junk);
    if (by_nul) begin
      put_char(CH_NUL);
    end else begin
      pending_chars.push_back('{ch: junk, eoi: 1'b1});
      n_queued++;
    end
  endfunction

  function automatic logic [7:0] random_space();
    case ($urandom_range(0, 3))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_LF;
      default: return CH_CR;
    endcase
  endfunction

  function automatic logic [7:0] random_name_char();
    logic [7:0] c;
    do
      c = 8'($urandom_range(1, 255));
    while (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR || c == CH_OPEN ||
           c == CH_CLOSE || c == CH_COMMA || c == CH_SEMI);
    return c;
  endfunction

  // a character that may be dropped, replaced or preceded by a stray byte
  function automatic void put_noisy(logic [7:0] c);
    if (noise_on && $urandom_range(0, 29) == 0) begin
      case ($urandom_range(0, 2))
        0: begin end
        1: begin
          put_char(8'($urandom_range(1, 255)));
          put_char(c);
        end
        default: put_char(8'($urandom_range(1, 255)));
      endcase
    end else begin
      put_char(c);
    end
  endfunction

  function automatic void put_sym(logic [7:0] c);
    if ($urandom_range(0, 3) == 0) put_noisy(random_space());
    put_noisy(c);
    if ($urandom_range(0, 3) == 0) put_noisy(random_space());
  endfunction

  function automatic void put_name();
    repeat ($urandom_range(1, 4)) put_noisy(random_name_char());
  endfunction

  // statements of calls with nested argument lists, closed by an end item
  function automatic void put_stream(int max_nest, int open_pct, int terms);
    int   d;
    int   pick;
    logic after_name;
    d = 0;
    put_name();
    after_name = 1'b1;
    for (int i = 0; i < terms; i++) begin
      pick = $urandom_range(0, 99);
      if (after_name && pick < open_pct && d < max_nest) begin
        put_sym(CH_OPEN);
        d++;
        if ($urandom_range(0, 5) == 0) begin
          put_sym(CH_CLOSE);
          d--;
          after_name = 1'b0;
        end else begin
          put_name();
          after_name = 1'b1;
        end
      end else if (d > 0 && pick < open_pct + (100 - open_pct) / 2) begin
        put_sym(CH_CLOSE);
        d--;
        after_name = 1'b0;
      end else begin
        put_sym((d > 0) ? CH_COMMA : CH_SEMI);
        put_name();
        after_name = 1'b1;
      end
    end
    while (d > 0) begin
      put_sym(CH_CLOSE);
      d--;
    end
    if ($urandom_range(0, 3) != 0) put_sym(CH_SEMI);
    put_finish($urandom_range(0, 2) == 0, 8'($urandom_range(0, 255)));
  endfunction

  // arbitrary bytes, delimiters favored
  function automatic void put_garbage();
    repeat ($urandom_range(1, 12)) begin
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 4))
          0:       put_char(CH_OPEN);
          1:       put_char(CH_CLOSE);
          2:       put_char(CH_COMMA);
          3:       put_char(CH_SEMI);
          default: put_char(random_space());
        endcase
      end else begin
        put_char(8'($urandom_range(1, 255)));
      end
    end
    put_finish($urandom_range(0, 2) == 0, 8'($urandom_range(0, 255)));
  endfunction

  function automatic void put_random_items(int count);
    int start;
    int pick;
    start = n_queued;
    while (n_queued - start < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        noise_on = 1'b0;
        put_stream(4, 30, $urandom_range(1, 10));
      end else if (pick < 80) begin
        noise_on = 1'b1;
        put_stream(6, 35, $urandom_range(1, 10));
      end else if (pick < 88) begin
        noise_on = 1'b0;
        put_stream(MAX_DEPTH + 2, 85, 24);
      end else begin
        put_garbage();
      end
    end
    noise_on = 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // sequencing
  // ---------------------------------------------------------------------------
  task automatic wait_idle();
    while (!(n_accepted == n_queued && predicted_events.size() == 0)) @(negedge clk_i);
    // items without results may still be in flight
    repeat (60) @(negedge clk_i);
  endtask

  task automatic write_trace(logic v);
    wait_idle();
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    trace_on = 1'b1;
    parse_reset();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_n = 1'b1;
    @(posedge clk_i);

    // directed: calls, empty list, stray delimiters, missing separators, open group
    put_text("f(a,b);");
    put_finish(1'b0, 8'hFF);
    put_text("g()");
    put_finish(1'b1, CH_NUL);
    put_text("()a,");
    put_finish(1'b0, 8'h00);
    put_text("x(y z;)\t");
    put_finish(1'b0, 8'h5A);
    put_text("a b(");
    put_finish(1'b0, 8'hA5);

    // trace off, then on, then off again, each with random streams
    write_trace(1'b0);
    put_random_items(150);
    write_trace(1'b1);
    put_random_items(200);

    write_trace(1'b0);
    put_random_items(150);

    wait_idle();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
